FILE: rtl/first_fit_block_allocator_defines.svh
// Assertion macros for the first-fit block allocator.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define FFBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define FFBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FFBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define FFBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/ffba_pkg.sv
// Package: types, constants and codes of the first-fit block allocator.
`timescale 1ns / 1ps
package ffba_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 24;
    localparam int HEAP_BYTES   = 1048576;
    localparam int CALLOC_CAP   = 1024 * 1024;

    localparam int ADDR_W = 20;
    localparam int LIM_W  = 21;
    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);

    localparam logic [LIM_W-1:0] HEAP_LIMIT_MAX   = LIM_W'(HEAP_BYTES);
    localparam logic [LIM_W-1:0] HEAP_LIMIT_RESET = LIM_W'(1048576);

    localparam logic [1:0] OP_MALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_REALLOC = 2'd2;
    localparam logic [1:0] OP_CALLOC  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OOM     = 2'd1;
    localparam logic [1:0] ST_ZERO    = 2'd2;
    localparam logic [1:0] ST_BADFREE = 2'd3;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [ADDR_W-1:0] request_size;
        logic [ADDR_W-1:0] block_address;
        logic [15:0]       element_count;
        logic [15:0]       element_bytes;
    } t_cmd;

    typedef struct packed {
        logic [ADDR_W-1:0] result_address;
        logic [1:0]        status;
    } t_rsp;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] length;
        logic              used;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic [IDX_W-1:0] raddr;
    } t_ram_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_FIND,
        S_FIT,
        S_FREE_OLD
    } t_state;

endpackage

FILE: rtl/ffba_ram.sv
// Block table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module ffba_ram
    import ffba_pkg::*;
(
    input  logic     i_clk,
    input  t_ram_req i_req,
    output t_entry   o_rdata
);

    t_entry r_mem [MAX_BLOCKS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/ffba_ctrl.sv
// Request sequencer: table scans, append, realloc release and result register.
`timescale 1ns / 1ps
module ffba_ctrl
    import ffba_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_cmd             i_cmd,
    input  logic [LIM_W-1:0] i_limit,
    output logic             o_busy,
    output logic             o_done,
    output t_rsp             o_rsp,
    output t_ram_req         o_ram_req,
    input  t_entry           i_rdata
);

    localparam logic [LIM_W-1:0] HDR   = LIM_W'(HEADER_BYTES);
    localparam logic [LIM_W:0]   HDR_X = (LIM_W + 1)'(HEADER_BYTES);
    localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_BLOCKS);
    localparam logic [31:0]      CAP   = 32'(CALLOC_CAP);

    t_state            r_state, n_state;
    logic [1:0]        r_op, n_op;
    logic [LIM_W-1:0]  r_size, n_size;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [31:0]       r_prod, n_prod;
    logic [CNT_W-1:0]  r_ptr, n_ptr;
    logic              r_chk_vld, n_chk_vld;
    logic [IDX_W-1:0]  r_chk_idx, n_chk_idx;
    logic [CNT_W-1:0]  r_total, n_total;
    logic [LIM_W-1:0]  r_break, n_break;
    logic [IDX_W-1:0]  r_old_idx, n_old_idx;
    t_entry            r_old_ent, n_old_ent;
    t_rsp              r_res, n_res;
    logic              r_done, n_done;

    logic              scan_more, scan_end, fit_hit, find_hit, app_fail, free_old;
    logic [LIM_W:0]    app_end;
    logic [LIM_W-1:0]  hit_payload, brk_payload;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_chk_vld <= 1'b0;
            r_total   <= '0;
            r_break   <= '0;
            r_done    <= 1'b0;
            r_ptr     <= '0;
        end else begin
            r_state   <= n_state;
            r_chk_vld <= n_chk_vld;
            r_total   <= n_total;
            r_break   <= n_break;
            r_done    <= n_done;
            r_ptr     <= n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_size    <= n_size;
        r_addr    <= n_addr;
        r_prod    <= n_prod;
        r_chk_idx <= n_chk_idx;
        r_old_idx <= n_old_idx;
        r_old_ent <= n_old_ent;
        r_res     <= n_res;
    end

    assign scan_more   = (r_ptr < r_total);
    assign scan_end    = !r_chk_vld && !scan_more;
    assign fit_hit     = r_chk_vld && !i_rdata.used && ({1'b0, i_rdata.length} >= r_size);
    assign hit_payload = {1'b0, i_rdata.start} + HDR;
    assign find_hit    = r_chk_vld && (hit_payload == {1'b0, r_addr});
    assign brk_payload = r_break + HDR;
    assign app_end     = {1'b0, r_break} + HDR_X + {1'b0, r_size};
    assign app_fail    = (r_total >= MAX_C) || (app_end > {1'b0, i_limit});
    assign free_old    = (r_op == OP_REALLOC) && (r_addr != '0);

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_size    = r_size;
        n_addr    = r_addr;
        n_prod    = r_prod;
        n_ptr     = r_ptr;
        n_chk_vld = 1'b0;
        n_chk_idx = r_chk_idx;
        n_total   = r_total;
        n_break   = r_break;
        n_old_idx = r_old_idx;
        n_old_ent = r_old_ent;
        n_res     = r_res;
        n_done    = 1'b0;

        o_ram_req.we    = 1'b0;
        o_ram_req.waddr = r_chk_idx;
        o_ram_req.wdata = '{start: i_rdata.start, length: i_rdata.length, used: 1'b1};
        o_ram_req.raddr = r_ptr[IDX_W-1:0];

        // issue the next table read while scanning
        if ((r_state == S_FIND || r_state == S_FIT) && scan_more) begin
            n_ptr     = r_ptr + 1'b1;
            n_chk_vld = 1'b1;
            n_chk_idx = r_ptr[IDX_W-1:0];
        end

        unique case (r_state)
            S_IDLE: begin
                n_ptr = '0;
                if (i_start) begin
                    n_op   = i_cmd.opcode;
                    n_size = {1'b0, i_cmd.request_size};
                    n_addr = i_cmd.block_address;
                    n_prod = {16'b0, i_cmd.element_count} * {16'b0, i_cmd.element_bytes};
                    n_res  = '{result_address: '0, status: ST_OK};
                    case (i_cmd.opcode)
                        OP_MALLOC: begin
                            if (i_cmd.request_size == '0) begin
                                n_res.status = ST_ZERO;
                                n_done       = 1'b1;
                            end else begin
                                n_state = S_FIT;
                            end
                        end
                        OP_FREE: begin
                            if (i_cmd.block_address == '0) begin
                                n_done = 1'b1;
                            end else begin
                                n_state = S_FIND;
                            end
                        end
                        OP_REALLOC: begin
                            if (i_cmd.block_address != '0) begin
                                n_state = S_FIND;
                            end else if (i_cmd.request_size == '0) begin
                                n_res.status = ST_ZERO;
                                n_done       = 1'b1;
                            end else begin
                                n_state = S_FIT;
                            end
                        end
                        default: begin
                            n_state = S_CALC;
                        end
                    endcase
                end
            end
            S_CALC: begin
                if (r_prod > CAP) begin
                    n_res.status = ST_OOM;
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                end else if (r_prod == '0) begin
                    n_res.status = ST_ZERO;
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_size  = r_prod[LIM_W-1:0];
                    n_state = S_FIT;
                end
            end
            S_FIND: begin
                if (find_hit) begin
                    n_chk_vld = 1'b0;
                    n_ptr     = '0;
                    if (!i_rdata.used) begin
                        n_res.status = ST_BADFREE;
                        n_done       = 1'b1;
                        n_state      = S_IDLE;
                    end else if (r_op == OP_FREE) begin
                        o_ram_req.we         = 1'b1;
                        o_ram_req.wdata.used = 1'b0;
                        n_done               = 1'b1;
                        n_state              = S_IDLE;
                    end else if ({1'b0, i_rdata.length} >= r_size) begin
                        n_res.result_address = r_addr;
                        n_done               = 1'b1;
                        n_state              = S_IDLE;
                    end else begin
                        // hold the old block until the new one is granted
                        n_old_idx = r_chk_idx;
                        n_old_ent = i_rdata;
                        n_state   = S_FIT;
                    end
                end else if (scan_end) begin
                    n_res.status = ST_BADFREE;
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_FIT: begin
                if (fit_hit) begin
                    n_chk_vld            = 1'b0;
                    o_ram_req.we         = 1'b1;
                    n_res.result_address = hit_payload[ADDR_W-1:0];
                    if (free_old) begin
                        n_state = S_FREE_OLD;
                    end else begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (scan_end) begin
                    if (app_fail) begin
                        n_res.status = ST_OOM;
                        n_done       = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        // append at the break
                        o_ram_req.we         = 1'b1;
                        o_ram_req.waddr      = r_total[IDX_W-1:0];
                        o_ram_req.wdata      = '{start: r_break[ADDR_W-1:0],
                                                 length: r_size[ADDR_W-1:0],
                                                 used: 1'b1};
                        n_res.result_address = brk_payload[ADDR_W-1:0];
                        n_total              = r_total + 1'b1;
                        n_break              = app_end[LIM_W-1:0];
                        if (free_old) begin
                            n_state = S_FREE_OLD;
                        end else begin
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_FREE_OLD: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = r_old_idx;
                o_ram_req.wdata = '{start: r_old_ent.start, length: r_old_ent.length,
                                    used: 1'b0};
                n_done          = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_res;

endmodule

FILE: rtl/first_fit_block_allocator.sv
// Top level of the first-fit block allocator: limit register, sequencer and table memory.
//
// Channel   Direction  Handshake              Payload
// command   in         start high, busy low   i_cmd (t_cmd)
// result    out        o_done, one cycle      o_rsp (t_rsp)
// config    in         i_cfg_we               i_cfg_wdata (heap limit)
//
// A beat with nothing to look up (zero-size malloc or realloc of address 0, free of
// address 0) answers in the cycle after it is taken. Calloc first checks the product
// in its own state. Each table walk reads one entry a cycle through the single
// registered read port of the table memory; realloc may walk the table twice, once to
// find the old block and once to fit the new one, and then releases the old block.
// Synchronous active-low reset empties the table and the break and sets the limit to
// 1 MiB; the table memory itself is not cleared. The receiver cannot stall: each
// result is shown for exactly one cycle, and busy drops in that same cycle.
`timescale 1ns / 1ps
`include "first_fit_block_allocator_defines.svh"
module first_fit_block_allocator
    import ffba_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_cmd             i_cmd,
    output logic             o_done,
    output t_rsp             o_rsp,
    input  logic             i_cfg_we,
    input  logic [LIM_W-1:0] i_cfg_wdata
);

    logic [LIM_W-1:0] r_heap_limit;
    logic [LIM_W-1:0] eff_limit;
    t_ram_req         ram_req;
    t_entry           ram_rdata;

    // heap limit register; write it only while idle, the block itself does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_limit <= HEAP_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_heap_limit <= i_cfg_wdata;
        end
    end

    // clamp the limit to the physical heap size
    assign eff_limit = (r_heap_limit < HEAP_LIMIT_MAX) ? r_heap_limit : HEAP_LIMIT_MAX;

    // sequencer: scans, append, release of the old block on realloc
    ffba_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_cmd     (i_cmd),
        .i_limit   (eff_limit),
        .o_busy    (busy),
        .o_done    (o_done),
        .o_rsp     (o_rsp),
        .o_ram_req (ram_req),
        .i_rdata   (ram_rdata)
    );

    // block table: start, length and used mark per entry. Accesses never overlap:
    // every write lands after the scans of its own beat, and the next beat starts later.
    ffba_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    `FFBA_ASSERT_NXT(a_accept_progress, i_clk, i_rst_n, start && !busy, busy || o_done, "beat taken without work or result")
    `FFBA_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, !busy, "result shown while busy")
    `FFBA_ASSERT_NXT(a_done_single, i_clk, i_rst_n, o_done && !start, !o_done, "result repeated")
    `FFBA_ASSERT_IMP(a_fail_zero_addr, i_clk, i_rst_n, o_done && (o_rsp.status != ST_OK), o_rsp.result_address == '0, "failed beat carries an address")

endmodule

FILE: sim/tb_first_fit_block_allocator.sv
// Self-checking testbench for the first-fit block allocator: directed table, then random beats.
`timescale 1ns / 1ps
module tb_first_fit_block_allocator;
    import ffba_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int RESET_TICKS = 8;
    // Longest walk is a realloc that misses: two full table scans plus overhead.
    localparam int SETTLE      = 2 * MAX_BLOCKS + 12;
    // Cycles with no beat taken and no grant seen before the run is called hung.
    localparam int STALL_LIMIT = 3000;

    // One row of the directed table. When fixed is set, want is the answer
    // typed in by hand; otherwise the heap predictor supplies it.
    typedef struct packed {
        t_cmd cmd;
        bit   fixed;
        t_rsp want;
    } t_row;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             start       = 1'b0;
    logic             busy;
    t_cmd             i_cmd       = '0;
    logic             o_done;
    t_rsp             o_rsp;
    logic             i_cfg_we    = 1'b0;
    logic [LIM_W-1:0] i_cfg_wdata = '0;

    first_fit_block_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Heap predictor: own copy of the block table, the break and the limit.
    // Only entries below blk_count are ever read, so the table needs no clear.
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] blk_start [MAX_BLOCKS];
    logic [ADDR_W-1:0] blk_len   [MAX_BLOCKS];
    bit                blk_used  [MAX_BLOCKS];
    logic [CNT_W-1:0]  blk_count = '0;
    logic [LIM_W-1:0]  heap_top  = '0;
    logic [LIM_W-1:0]  heap_cap  = HEAP_LIMIT_RESET;

    t_rsp grants_due [$];
    int   errors      = 0;
    int   idle_cycles = 0;
    bit   dense       = 1'b0;

    // First fit over the table, then append at the break. Blocks never split.
    function automatic logic [1:0] claim_bytes(input int unsigned size,
                                               output logic [ADDR_W-1:0] payload);
        int          i;
        int unsigned ceiling;
        int unsigned stop;
        payload = '0;
        if (size == 0) return ST_ZERO;
        for (i = 0; i < int'(blk_count); i++) begin
            if (!blk_used[i] && 32'(blk_len[i]) >= size) begin
                blk_used[i] = 1'b1;
                payload = ADDR_W'(blk_start[i] + HEADER_BYTES);
                return ST_OK;
            end
        end
        // Table full: no room for another entry.
        if (int'(blk_count) >= MAX_BLOCKS) return ST_OOM;
        ceiling = (int'(heap_cap) < HEAP_BYTES) ? int'(heap_cap) : HEAP_BYTES;
        stop = int'(heap_top) + HEADER_BYTES + size;
        // Heap exhausted: leave everything as it was.
        if (stop > ceiling) return ST_OOM;
        blk_start[blk_count] = ADDR_W'(heap_top);
        blk_len[blk_count]   = ADDR_W'(size);
        blk_used[blk_count]  = 1'b1;
        payload   = ADDR_W'(heap_top + HEADER_BYTES);
        blk_count = blk_count + 1'b1;
        heap_top  = LIM_W'(stop);
        return ST_OK;
    endfunction

    // Table index whose payload address matches, or -1.
    function automatic int locate_block(input logic [ADDR_W-1:0] payload);
        int i;
        for (i = 0; i < int'(blk_count); i++)
            if (32'(blk_start[i]) + HEADER_BYTES == 32'(payload)) return i;
        return -1;
    endfunction

    // Advance the predicted heap by one request and return its grant.
    function automatic t_rsp predict_grant(input t_cmd c);
        t_rsp              r;
        int                slot;
        logic [ADDR_W-1:0] payload;
        int unsigned       total;
        r = '0;
        case (c.opcode)
            OP_MALLOC: begin
                r.status = claim_bytes(32'(c.request_size), payload);
                r.result_address = payload;
            end
            OP_FREE: begin
                // Free of address zero is a no-op with status ok.
                if (c.block_address != '0) begin
                    slot = locate_block(c.block_address);
                    if (slot < 0 || !blk_used[slot]) r.status = ST_BADFREE;
                    else blk_used[slot] = 1'b0;
                end
            end
            OP_REALLOC: begin
                if (c.block_address == '0) begin
                    r.status = claim_bytes(32'(c.request_size), payload);
                    r.result_address = payload;
                end else begin
                    slot = locate_block(c.block_address);
                    if (slot < 0 || !blk_used[slot]) begin
                        r.status = ST_BADFREE;
                    end else if (blk_len[slot] >= c.request_size) begin
                        // Shrink or same size keeps the block in place.
                        r.result_address = c.block_address;
                    end else begin
                        // Move: old block stays used if the new one fails.
                        r.status = claim_bytes(32'(c.request_size), payload);
                        r.result_address = payload;
                        if (r.status == ST_OK) blk_used[slot] = 1'b0;
                    end
                end
            end
            OP_CALLOC: begin
                total = 32'(c.element_count) * 32'(c.element_bytes);
                if (total > CALLOC_CAP) begin
                    r.status = ST_OOM;
                end else begin
                    r.status = claim_bytes(total, payload);
                    r.result_address = payload;
                end
            end
        endcase
        return r;
    endfunction

    function automatic t_row make_row(input logic [1:0] op, input logic [ADDR_W-1:0] size,
                                      input logic [ADDR_W-1:0] addr, input logic [15:0] cnt,
                                      input logic [15:0] ebytes, input bit fixed,
                                      input logic [ADDR_W-1:0] want_addr,
                                      input logic [1:0] want_st);
        t_row row;
        row.cmd.opcode         = op;
        row.cmd.request_size   = size;
        row.cmd.block_address  = addr;
        row.cmd.element_count  = cnt;
        row.cmd.element_bytes  = ebytes;
        row.fixed              = fixed;
        row.want.result_address = want_addr;
        row.want.status        = want_st;
        return row;
    endfunction

    // Request sizes: mostly small so the table fills before the heap does;
    // full-width noise only once appends can no longer happen.
    function automatic logic [ADDR_W-1:0] draw_size();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 3) return '0;
        if (pick < 8 && int'(blk_count) >= MAX_BLOCKS) return ADDR_W'($urandom);
        if (pick < 20) return ADDR_W'($urandom_range(1, 64));
        return ADDR_W'($urandom_range(1, 4096));
    endfunction

    // Addresses: mostly live or freed payloads from the table, some zero,
    // some random noise.
    function automatic logic [ADDR_W-1:0] pick_address();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) return '0;
        if (pick < 25 || blk_count == '0) return ADDR_W'($urandom);
        return ADDR_W'(blk_start[$urandom_range(0, int'(blk_count) - 1)] + HEADER_BYTES);
    endfunction

    // ------------------------------------------------------------------
    // Command side: hold start until a beat is taken, then log the grant.
    // ------------------------------------------------------------------
    task automatic issue_request(input t_cmd c, input bit fixed, input t_rsp want);
        int   gap;
        t_rsp guess;
        gap = dense ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        // Beat taken at this edge: advance the predictor in step with it.
        guess = predict_grant(c);
        grants_due.push_back(fixed ? want : guess);
    endtask

    // Drop start, wait for every grant, then let the sequencer wind down.
    task automatic drain_and_settle();
        start <= 1'b0;
        while (grants_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Write the heap limit only while the block is idle.
    task automatic set_heap_limit(input logic [LIM_W-1:0] value);
        drain_and_settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        heap_cap = value;
    endtask

    task automatic run_phase(input int beats);
        t_cmd        c;
        t_rsp        none;
        int unsigned pick;
        none = '0;
        for (int n = 0; n < beats; n++) begin
            // Switch between back-to-back bursts and gappy traffic.
            if (n % 64 == 0) dense = ($urandom_range(0, 3) == 0);
            // Fill every field with noise, then shape the ones the opcode reads.
            c.opcode        = 2'($urandom);
            c.request_size  = ADDR_W'($urandom);
            c.block_address = ADDR_W'($urandom);
            c.element_count = 16'($urandom);
            c.element_bytes = 16'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                c.opcode = OP_MALLOC;
                c.request_size = draw_size();
            end else if (pick < 60) begin
                c.opcode = OP_FREE;
                c.block_address = pick_address();
            end else if (pick < 80) begin
                c.opcode = OP_REALLOC;
                c.block_address = pick_address();
                c.request_size = draw_size();
            end else begin
                c.opcode = OP_CALLOC;
                if ($urandom_range(0, 19) != 0) begin
                    c.element_count = 16'($urandom_range(0, 64));
                    c.element_bytes = 16'($urandom_range(1, 128));
                end
            end
            issue_request(c, 1'b0, none);
        end
    endtask

    // ------------------------------------------------------------------
    // Grant checker: every o_done beat must match the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_grant
        t_rsp want;
        if (i_rst_n && o_done) begin
            if (grants_due.size() == 0) begin
                $error("unexpected grant: result_address %0d status %0d",
                       o_rsp.result_address, o_rsp.status);
                errors++;
            end else begin
                want = grants_due.pop_front();
                if (o_rsp.result_address !== want.result_address) begin
                    $error("result_address: expected %0d, got %0d",
                           want.result_address, o_rsp.result_address);
                    errors++;
                end
                if (o_rsp.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_rsp.status);
                    errors++;
                end
            end
        end
    end

    // Hang detector: reset the count on any beat taken or grant seen.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT) begin
                $display("tb_first_fit_block_allocator failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_row plan [$];
        repeat (RESET_TICKS) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table. Break starts at zero, limit at 1 MiB.
        //                   op          size         addr         cnt       bytes   fixed
        // zero-size requests of each kind
        plan.push_back(make_row(OP_MALLOC,  20'd0,       20'd0,       16'd0,     16'd0,  1'b1, 20'd0,  ST_ZERO));
        plan.push_back(make_row(OP_CALLOC,  20'd0,       20'd0,       16'd0,     16'd5,  1'b1, 20'd0,  ST_ZERO));
        plan.push_back(make_row(OP_REALLOC, 20'd0,       20'd0,       16'd0,     16'd0,  1'b1, 20'd0,  ST_ZERO));
        // free of address zero does nothing
        plan.push_back(make_row(OP_FREE,    20'd0,       20'd0,       16'd0,     16'd0,  1'b1, 20'd0,  ST_OK));
        // unknown address on an empty table
        plan.push_back(make_row(OP_FREE,    20'd0,       20'd24,      16'd0,     16'd0,  1'b1, 20'd0,  ST_BADFREE));
        plan.push_back(make_row(OP_REALLOC, 20'd5,       20'd100,     16'd0,     16'd0,  1'b1, 20'd0,  ST_BADFREE));
        // calloc product far over 1 MiB
        plan.push_back(make_row(OP_CALLOC,  20'd0,       20'd0,       16'hFFFF,  16'hFFFF, 1'b1, 20'd0, ST_OOM));
        // heap exhausted on the largest request
        plan.push_back(make_row(OP_MALLOC,  20'hFFFFF,   20'd0,       16'd0,     16'd0,  1'b1, 20'd0,  ST_OOM));
        // first block sits right after its header
        plan.push_back(make_row(OP_MALLOC,  20'd100,     20'd0,       16'd0,     16'd0,  1'b1, 20'd24, ST_OK));
        plan.push_back(make_row(OP_MALLOC,  20'd50,      20'd0,       16'd0,     16'd0,  1'b0, 20'd0,  ST_OK));
        plan.push_back(make_row(OP_FREE,    20'd0,       20'd24,      16'd0,     16'd0,  1'b1, 20'd0,  ST_OK));
        // double free, then realloc of the freed block
        plan.push_back(make_row(OP_FREE,    20'd0,       20'd24,      16'd0,     16'd0,  1'b1, 20'd0,  ST_BADFREE));
        plan.push_back(make_row(OP_REALLOC, 20'd10,      20'd24,      16'd0,     16'd0,  1'b1, 20'd0,  ST_BADFREE));
        // reuse the freed block, then resize it in place
        plan.push_back(make_row(OP_MALLOC,  20'd80,      20'd0,       16'd0,     16'd0,  1'b0, 20'd0,  ST_OK));
        plan.push_back(make_row(OP_REALLOC, 20'd100,     20'd24,      16'd0,     16'd0,  1'b0, 20'd0,  ST_OK));
        plan.push_back(make_row(OP_REALLOC, 20'd60,      20'd24,      16'd0,     16'd0,  1'b0, 20'd0,  ST_OK));
        // grow: moves to a new block and frees the old one
        plan.push_back(make_row(OP_REALLOC, 20'd200,     20'd148,     16'd0,     16'd0,  1'b0, 20'd0,  ST_OK));
        // grow that cannot fit keeps the old block
        plan.push_back(make_row(OP_REALLOC, 20'hFFFFF,   20'd24,      16'd0,     16'd0,  1'b0, 20'd0,  ST_OOM));
        // calloc of exactly 1 MiB passes the cap but not the heap
        plan.push_back(make_row(OP_CALLOC,  20'd0,       20'd0,       16'd1024,  16'd1024, 1'b0, 20'd0, ST_OOM));
        plan.push_back(make_row(OP_CALLOC,  20'd0,       20'd0,       16'd3,     16'd7,  1'b0, 20'd0,  ST_OK));
        // addresses that hit no payload, then callocs with one factor of 0xFFFF
        plan.push_back(make_row(OP_FREE,    20'd0,       20'd25,      16'd0,     16'd0,  1'b1, 20'd0,  ST_BADFREE));
        plan.push_back(make_row(OP_FREE,    20'hFFFFF,   20'hFFFFF,   16'hFFFF,  16'hFFFF, 1'b1, 20'd0, ST_BADFREE));
        plan.push_back(make_row(OP_CALLOC,  20'd0,       20'd0,       16'hFFFF,  16'd1,  1'b0, 20'd0,  ST_OK));
        plan.push_back(make_row(OP_CALLOC,  20'd0,       20'd0,       16'd1,     16'hFFFF, 1'b0, 20'd0, ST_OK));

        foreach (plan[k]) issue_request(plan[k].cmd, plan[k].fixed, plan[k].want);

        // Limit of zero: every append fails, only reuse can succeed.
        set_heap_limit('0);
        run_phase(40);

        // Tight limit a little above the break: appends run out of heap.
        set_heap_limit(LIM_W'(heap_top) + LIM_W'(8192));
        run_phase(200);

        // Full limit: the table fills up and first fit does the rest.
        set_heap_limit(HEAP_LIMIT_MAX);
        run_phase(1710);

        drain_and_settle();
        if (errors == 0) begin
            $display("tb_first_fit_block_allocator passed");
        end else begin
            $display("tb_first_fit_block_allocator failed");
        end
        $finish;
    end

endmodule
